FILE: src/lidar_scan_frame_parser_assert.svh
// Assertion macros shared by the checker files of the lidar scan frame parser.
`ifndef LIDAR_SCAN_FRAME_PARSER_ASSERT_SVH
`define LIDAR_SCAN_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LSFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsfp: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsfp: next-cycle check failed");

`endif

FILE: src/lsfp_pkg.sv
// Package of constants, command and result types for the lidar scan frame parser.
package lsfp_pkg;

  localparam int ANGLE_BINS        = 360;
  localparam int POINTS_PER_SECTOR = 22;

  localparam int GRP_W  = $clog2(POINTS_PER_SECTOR + 1);
  localparam int IDX_W  = $clog2(30 * POINTS_PER_SECTOR);
  localparam int BINS_W = $clog2(ANGLE_BINS + 1);
  localparam int CMP_W  = (IDX_W > BINS_W) ? IDX_W : BINS_W;

  // The start angle divided by 2250 is at most 29, taken as a reciprocal product.
  localparam int          QUO_W        = 5;
  localparam int          RECIP_SHIFT  = 27;
  localparam logic [15:0] SECTOR_RECIP = 16'd59653;

  // Division of a byte by three.
  localparam logic [7:0] THIRD_RECIP = 8'd171;
  localparam int         THIRD_SHIFT = 9;
  localparam logic [7:0] LEN_BIAS    = 8'd5;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h00;
  localparam logic [7:0] SYNC_C = 8'h61;
  localparam logic [7:0] SYNC_D = 8'hAD;

  localparam logic [15:0] RANGE_FLOOR = 16'd2;
  localparam logic [15:0] NEAR_RANGE  = 16'd250;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [3:0] {
    OP_VERSION,
    OP_COUNT,
    OP_SPEED,
    OP_OFS_HI,
    OP_OFS_LO,
    OP_START_HI,
    OP_START_LO,
    OP_SIGNAL,
    OP_RANGE_HI,
    OP_RANGE_LO,
    OP_FRAME
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [GRP_W-1:0] group;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  angle_index;
    logic [7:0]  signal_level;
    logic [15:0] range_value;
    logic [7:0]  proto_version;
    logic [7:0]  rotation_speed;
    logic [6:0]  point_count;
    logic [15:0] offset_angle;
    logic [15:0] first_angle;
    logic [15:0] frames_seen;
  } res_t;

endpackage

FILE: src/lsfp_if.sv
// Handshake interfaces for the byte input and the result output channels.
interface lsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lsfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [8:0]  angle_index;
  logic [7:0]  signal_level;
  logic [15:0] range_value;
  logic [7:0]  proto_version;
  logic [7:0]  rotation_speed;
  logic [6:0]  point_count;
  logic [15:0] offset_angle;
  logic [15:0] first_angle;
  logic [15:0] frames_seen;

  modport source (
    output valid, input ready, output kind, output angle_index, output signal_level,
    output range_value, output proto_version, output rotation_speed, output point_count,
    output offset_angle, output first_angle, output frames_seen
  );
  modport sink (
    input valid, output ready, input kind, input angle_index, input signal_level,
    input range_value, input proto_version, input rotation_speed, input point_count,
    input offset_angle, input first_angle, input frames_seen
  );
endinterface

FILE: src/lsfp_queue.sv
// Short command queue between the frame tracker and the executing back end.
module lsfp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lsfp_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lsfp_pkg::cmd_t cmd_o
);
  import lsfp_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: src/lsfp_front.sv
// Frame tracker: follows the byte position and turns useful words into commands.
module lsfp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  output logic           in_ready_o,
  input  logic           q_full_i,
  output logic           push_o,
  output lsfp_pkg::cmd_t cmd_o
);
  import lsfp_pkg::*;

  localparam logic [3:0] ST_SYNC_A   = 4'd0;
  localparam logic [3:0] ST_SYNC_B   = 4'd1;
  localparam logic [3:0] ST_SKIP_A   = 4'd2;
  localparam logic [3:0] ST_VERSION  = 4'd3;
  localparam logic [3:0] ST_SYNC_C   = 4'd4;
  localparam logic [3:0] ST_SYNC_D   = 4'd5;
  localparam logic [3:0] ST_SKIP_B   = 4'd6;
  localparam logic [3:0] ST_LENGTH   = 4'd7;
  localparam logic [3:0] ST_SPEED    = 4'd8;
  localparam logic [3:0] ST_OFS_HI   = 4'd9;
  localparam logic [3:0] ST_OFS_LO   = 4'd10;
  localparam logic [3:0] ST_START_HI = 4'd11;
  localparam logic [3:0] ST_START_LO = 4'd12;
  localparam logic [3:0] ST_POINTS   = 4'd13;
  localparam logic [3:0] ST_CLOSE    = 4'd14;

  localparam logic [2:0] PH_SIGNAL   = 3'd0;
  localparam logic [2:0] PH_RANGE_HI = 3'd1;
  localparam logic [2:0] PH_RANGE_LO = 3'd2;
  localparam logic [2:0] PH_LAST     = 3'd5;

  logic [3:0]       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [GRP_W-1:0] group_q, group_d;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    group_d     = group_q;
    push_o      = 1'b0;
    cmd_o.op    = OP_FRAME;
    cmd_o.data  = in_byte_i;
    cmd_o.group = group_q;
    if (accept) begin
      unique case (state_q)
        ST_SYNC_A: state_d = (in_byte_i == SYNC_A) ? ST_SYNC_B : ST_SYNC_A;
        ST_SYNC_B: state_d = (in_byte_i == SYNC_B) ? ST_SKIP_A : ST_SYNC_A;
        ST_SKIP_A: state_d = ST_VERSION;
        ST_VERSION: begin
          push_o   = 1'b1;
          cmd_o.op = OP_VERSION;
          state_d  = ST_SYNC_C;
        end
        ST_SYNC_C: state_d = (in_byte_i == SYNC_C) ? ST_SYNC_D : ST_SYNC_A;
        ST_SYNC_D: state_d = (in_byte_i == SYNC_D) ? ST_SKIP_B : ST_SYNC_A;
        ST_SKIP_B: state_d = ST_LENGTH;
        ST_LENGTH: begin
          push_o   = 1'b1;
          cmd_o.op = OP_COUNT;
          state_d  = ST_SPEED;
        end
        ST_SPEED: begin
          push_o   = 1'b1;
          cmd_o.op = OP_SPEED;
          state_d  = ST_OFS_HI;
        end
        ST_OFS_HI: begin
          push_o   = 1'b1;
          cmd_o.op = OP_OFS_HI;
          state_d  = ST_OFS_LO;
        end
        ST_OFS_LO: begin
          push_o   = 1'b1;
          cmd_o.op = OP_OFS_LO;
          state_d  = ST_START_HI;
        end
        ST_START_HI: begin
          push_o   = 1'b1;
          cmd_o.op = OP_START_HI;
          state_d  = ST_START_LO;
        end
        ST_START_LO: begin
          push_o   = 1'b1;
          cmd_o.op = OP_START_LO;
          state_d  = ST_POINTS;
          phase_d  = PH_SIGNAL;
          group_d  = '0;
        end
        ST_POINTS: begin
          unique case (phase_q)
            PH_SIGNAL: begin
              push_o   = 1'b1;
              cmd_o.op = OP_SIGNAL;
              phase_d  = PH_RANGE_HI;
              // The signal word after the last group is followed by the closing word.
              if (group_q == GRP_W'(POINTS_PER_SECTOR)) begin
                state_d = ST_CLOSE;
              end
            end
            PH_RANGE_HI: begin
              push_o   = 1'b1;
              cmd_o.op = OP_RANGE_HI;
              phase_d  = PH_RANGE_LO;
            end
            PH_RANGE_LO: begin
              push_o   = 1'b1;
              cmd_o.op = OP_RANGE_LO;
              phase_d  = phase_q + 1'b1;
            end
            PH_LAST: begin
              phase_d = PH_SIGNAL;
              group_d = group_q + 1'b1;
            end
            default: phase_d = phase_q + 1'b1;
          endcase
        end
        ST_CLOSE: begin
          push_o   = 1'b1;
          cmd_o.op = OP_FRAME;
          state_d  = ST_SYNC_A;
        end
        default: state_d = ST_SYNC_A;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC_A;
      phase_q <= PH_SIGNAL;
      group_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      group_q <= group_d;
    end
  end

endmodule

FILE: src/lsfp_back.sv
// Back end: holds the header fields, assembles points and registers the results.
module lsfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  lsfp_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lsfp_pkg::res_t res_o
);
  import lsfp_pkg::*;

  logic [7:0]       version_q, version_d;
  logic [6:0]       count_q, count_d;
  logic [7:0]       speed_q, speed_d;
  logic [15:0]      ofs_q, ofs_d;
  logic [15:0]      start_q, start_d;
  logic [7:0]       range_hi_q, range_hi_d;
  logic [7:0]       signal_q, signal_d;
  logic [15:0]      frames_q, frames_d;
  logic [31:0]      prod_q;
  logic [IDX_W-1:0] base_q;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             take;
  logic [CMP_W-1:0] idx;
  logic             in_range;
  logic [7:0]       len_diff;
  logic [15:0]      len_third;
  logic [15:0]      range_raw;
  logic [15:0]      range_fix;
  logic [15:0]      frames_inc;

  assign take        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o   = take;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign idx        = CMP_W'(base_q) + CMP_W'(cmd_i.group);
  assign in_range   = (idx < CMP_W'(ANGLE_BINS));
  assign len_diff   = cmd_i.data - LEN_BIAS;
  assign len_third  = 16'(len_diff) * 16'(THIRD_RECIP);
  assign range_raw  = {range_hi_q, cmd_i.data};
  assign range_fix  = (range_raw > RANGE_FLOOR) ? range_raw : NEAR_RANGE;
  assign frames_inc = frames_q + 16'd1;

  always_comb begin
    version_d   = version_q;
    count_d     = count_q;
    speed_d     = speed_q;
    ofs_d       = ofs_q;
    start_d     = start_q;
    range_hi_d  = range_hi_q;
    signal_d    = signal_q;
    frames_d    = frames_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    if (take) begin
      unique case (cmd_i.op)
        OP_VERSION:  version_d = cmd_i.data;
        OP_COUNT: begin
          count_d = (cmd_i.data < LEN_BIAS) ? 7'd0 : len_third[THIRD_SHIFT +: 7];
        end
        OP_SPEED:    speed_d = cmd_i.data;
        OP_OFS_HI:   ofs_d = {cmd_i.data, 8'd0};
        OP_OFS_LO:   ofs_d = {ofs_q[15:8], cmd_i.data};
        OP_START_HI: start_d = {cmd_i.data, 8'd0};
        OP_START_LO: start_d = {start_q[15:8], cmd_i.data};
        OP_SIGNAL:   signal_d = cmd_i.data;
        OP_RANGE_HI: range_hi_d = cmd_i.data;
        OP_RANGE_LO: begin
          range_hi_d = range_hi_q;
          if (in_range) begin
            out_valid_d          = 1'b1;
            res_d.kind           = KIND_POINT;
            res_d.angle_index    = 9'(idx);
            res_d.signal_level   = signal_q;
            res_d.range_value    = range_fix;
            res_d.proto_version  = version_q;
            res_d.rotation_speed = speed_q;
            res_d.point_count    = count_q;
            res_d.offset_angle   = ofs_q;
            res_d.first_angle    = start_q;
            res_d.frames_seen    = frames_q;
          end
        end
        OP_FRAME: begin
          frames_d             = frames_inc;
          out_valid_d          = 1'b1;
          res_d.kind           = KIND_FRAME;
          res_d.angle_index    = '0;
          res_d.signal_level   = '0;
          res_d.range_value    = '0;
          res_d.proto_version  = version_q;
          res_d.rotation_speed = speed_q;
          res_d.point_count    = count_q;
          res_d.offset_angle   = ofs_q;
          res_d.first_angle    = start_q;
          res_d.frames_seen    = frames_inc;
        end
        default: ;
      endcase
    end
  end

  // The sector base is formed from the start angle through prod_q and then base_q, and it
  // settles before the first point of a frame can arrive, as its signal and high distance
  // commands lie in between.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q   <= '0;
      count_q     <= '0;
      speed_q     <= '0;
      ofs_q       <= '0;
      start_q     <= '0;
      range_hi_q  <= '0;
      signal_q    <= '0;
      frames_q    <= '0;
      prod_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      version_q   <= version_d;
      count_q     <= count_d;
      speed_q     <= speed_d;
      ofs_q       <= ofs_d;
      start_q     <= start_d;
      range_hi_q  <= range_hi_d;
      signal_q    <= signal_d;
      frames_q    <= frames_d;
      prod_q      <= 32'(start_q) * 32'(SECTOR_RECIP);
      base_q      <= IDX_W'(prod_q[RECIP_SHIFT +: QUO_W] * POINTS_PER_SECTOR);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

FILE: src/lidar_scan_frame_parser.sv
// Top level of the lidar scan frame parser: frame tracker, command queue and back end.
//
//   Channel  Direction  Word
//   rx_i     in         one byte of the sensor's serial stream
//   res_o    out        one scan point or one frame-completed record
//
// A byte taken is written into the command queue, then executed from there by the back end
// into the result register, from which its result, if any, drives res_o. One byte can be
// taken in every cycle while the queue is not full. The four-entry command queue lets
// the tracker keep taking bytes while a result waits; rx_i.ready falls only when the queue is full.
// Reset clears the tracker to hunting for the header and all header fields to zero.
module lidar_scan_frame_parser (
  input logic       clk_i,
  input logic       rst_ni,
  lsfp_in_if.sink   rx_i,
  lsfp_out_if.source res_o
);
  import lsfp_pkg::*;

  logic rx_ready;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic out_valid;
  res_t res;

  assign rx_i.ready = rx_ready;

  lsfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lsfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  lsfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.valid          = out_valid;
  assign res_o.kind           = res.kind;
  assign res_o.angle_index    = res.angle_index;
  assign res_o.signal_level   = res.signal_level;
  assign res_o.range_value    = res.range_value;
  assign res_o.proto_version  = res.proto_version;
  assign res_o.rotation_speed = res.rotation_speed;
  assign res_o.point_count    = res.point_count;
  assign res_o.offset_angle   = res.offset_angle;
  assign res_o.first_angle    = res.first_angle;
  assign res_o.frames_seen    = res.frames_seen;

endmodule

FILE: src/lsfp_checker.sv
// Port checker for the lidar scan frame parser and its bind to the top level.
`include "lidar_scan_frame_parser_assert.svh"

module lsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  lsfp_in_if.sink    rx_i,
  lsfp_out_if.source res_o
);
  import lsfp_pkg::*;

  logic        point_out;
  logic        frame_out;
  logic        frame_clear;
  logic        point_ok;
  logic [32:0] held_word;

  assign point_out   = res_o.valid && (res_o.kind == KIND_POINT);
  assign frame_out   = res_o.valid && (res_o.kind == KIND_FRAME);
  assign frame_clear = (res_o.angle_index == '0) && (res_o.signal_level == '0)
                       && (res_o.range_value == '0);
  assign point_ok    = (res_o.range_value > RANGE_FLOOR)
                       && (int'(res_o.angle_index) < ANGLE_BINS);
  assign held_word   = {res_o.kind, res_o.range_value, res_o.frames_seen};

  `LSFP_ASSERT_IMPL(a_frame_clear, frame_out, frame_clear)
  `LSFP_ASSERT_IMPL(a_point_range, point_out, point_ok)
  `LSFP_ASSERT_IMPL(a_count_max, res_o.valid, res_o.point_count <= 7'd83)
  `LSFP_ASSERT_NEXT(a_out_hold, res_o.valid && !res_o.ready, res_o.valid && $stable(held_word))
  `LSFP_ASSERT_IMPL(a_stall_cause, !rx_i.ready, res_o.valid)

endmodule

bind lidar_scan_frame_parser lsfp_checker u_lsfp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rx_i   (rx_i),
  .res_o  (res_o)
);

FILE: sim/lidar_scan_frame_parser_checker.sv
// Checker that predicts the parser's result words from accepted bytes and compares them.
`timescale 1ns / 1ps

module lidar_scan_frame_parser_checker
  import lsfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lsfp_in_if   rx_i,
  lsfp_out_if  res_o,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int HDR_LEN    = 13;
  localparam int FRAME_LAST = HDR_LEN + 6 * POINTS_PER_SECTOR + 1;

  logic [7:0]  frame_pos;
  logic [7:0]  version_q;
  logic [6:0]  count_q;
  logic [7:0]  speed_q;
  logic [15:0] offset_q;
  logic [15:0] start_q;
  logic [15:0] range_q;
  logic [7:0]  signal_q;
  logic [15:0] frames_done;

  res_t scan_records_q[$];
  res_t next_rec;
  res_t seen_rec;
  bit   next_hit;
  int   mismatch_count;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    mismatch_count++;
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
  endtask

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) report_mismatch(what, exp_v, got_v);
  endtask

  function automatic res_t with_header(input res_t rec);
    res_t r;
    r = rec;
    r.proto_version  = version_q;
    r.rotation_speed = speed_q;
    r.point_count    = count_q;
    r.offset_angle   = offset_q;
    r.first_angle    = start_q;
    r.frames_seen    = frames_done;
    return r;
  endfunction

  task parse_rx_byte(input logic [7:0] b, output bit hit, output res_t rec);
    int        rel;
    int        grp;
    int        ph;
    int        idx;
    logic [15:0] range_word;
    hit = 1'b0;
    rec = '0;
    case (frame_pos)
      8'd0: frame_pos = (b == SYNC_A) ? 8'd1 : 8'd0;
      8'd1: frame_pos = (b == SYNC_B) ? 8'd2 : 8'd0;
      8'd2: frame_pos = 8'd3;
      8'd3: begin
        version_q = b;
        frame_pos = 8'd4;
      end
      8'd4: frame_pos = (b == SYNC_C) ? 8'd5 : 8'd0;
      8'd5: frame_pos = (b == SYNC_D) ? 8'd6 : 8'd0;
      8'd6: frame_pos = 8'd7;
      8'd7: begin
        count_q   = (int'(b) < 5) ? 7'd0 : 7'((int'(b) - 5) / 3);
        frame_pos = 8'd8;
      end
      8'd8: begin
        speed_q   = b;
        frame_pos = 8'd9;
      end
      8'd9: begin
        offset_q  = {b, 8'h00};
        frame_pos = 8'd10;
      end
      8'd10: begin
        offset_q  = {offset_q[15:8], b};
        frame_pos = 8'd11;
      end
      8'd11: begin
        start_q   = {b, 8'h00};
        frame_pos = 8'd12;
      end
      8'd12: begin
        start_q   = {start_q[15:8], b};
        frame_pos = 8'd13;
      end
      default: begin
        if (int'(frame_pos) >= FRAME_LAST) begin
          frames_done = frames_done + 16'd1;
          frame_pos   = 8'd0;
          rec         = '0;
          rec.kind    = KIND_FRAME;
          rec         = with_header(rec);
          hit         = 1'b1;
        end else begin
          rel       = int'(frame_pos) - HDR_LEN;
          grp       = rel / 6;
          ph        = rel % 6;
          idx       = (int'(start_q) / 2250) * POINTS_PER_SECTOR + grp;
          frame_pos = frame_pos + 8'd1;
          if (ph == 0) begin
            signal_q = b;
          end else if (ph == 1) begin
            range_q = {b, 8'h00};
          end else if (ph == 2) begin
            range_q    = {range_q[15:8], b};
            range_word = (range_q > 16'd2) ? range_q : 16'd250;
            if (idx < ANGLE_BINS) begin
              rec              = '0;
              rec.kind         = KIND_POINT;
              rec.angle_index  = 9'(idx);
              rec.signal_level = signal_q;
              rec.range_value  = range_word;
              rec              = with_header(rec);
              hit              = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos   = '0;
      version_q   = '0;
      count_q     = '0;
      speed_q     = '0;
      offset_q    = '0;
      start_q     = '0;
      range_q     = '0;
      signal_q    = '0;
      frames_done = '0;
      scan_records_q.delete();
      pending_o <= 0;
    end else begin
      if (res_o.valid && res_o.ready) begin
        seen_rec = '{kind: res_o.kind, angle_index: res_o.angle_index,
                     signal_level: res_o.signal_level, range_value: res_o.range_value,
                     proto_version: res_o.proto_version,
                     rotation_speed: res_o.rotation_speed,
                     point_count: res_o.point_count, offset_angle: res_o.offset_angle,
                     first_angle: res_o.first_angle, frames_seen: res_o.frames_seen};
        if (scan_records_q.size() == 0) begin
          report_mismatch("result word with none pending, kind", 0, seen_rec.kind);
        end else begin
          next_rec = scan_records_q.pop_front();
          check_field("kind", next_rec.kind, seen_rec.kind);
          check_field("angle_index", next_rec.angle_index, seen_rec.angle_index);
          check_field("signal_level", next_rec.signal_level, seen_rec.signal_level);
          check_field("range_value", next_rec.range_value, seen_rec.range_value);
          check_field("proto_version", next_rec.proto_version, seen_rec.proto_version);
          check_field("rotation_speed", next_rec.rotation_speed, seen_rec.rotation_speed);
          check_field("point_count", next_rec.point_count, seen_rec.point_count);
          check_field("offset_angle", next_rec.offset_angle, seen_rec.offset_angle);
          check_field("first_angle", next_rec.first_angle, seen_rec.first_angle);
          check_field("frames_seen", next_rec.frames_seen, seen_rec.frames_seen);
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        parse_rx_byte(rx_i.rx_byte, next_hit, next_rec);
        if (next_hit) scan_records_q.push_back(next_rec);
      end
      pending_o <= scan_records_q.size();
    end
  end

endmodule

FILE: sim/lidar_scan_frame_parser_tb.sv
// Testbench top for the lidar scan frame parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module lidar_scan_frame_parser_tb;
  import lsfp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 600;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   stall_pct;
  int   bytes_sent;
  int   cycle_count;
  int   fail_count;
  int   pending;

  lsfp_in_if  rx_if ();
  lsfp_out_if res_if ();

  lidar_scan_frame_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  lidar_scan_frame_parser_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .res_o        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [7:0] code,
                             input logic [7:0] speed, input logic [15:0] ofs,
                             input logic [15:0] start);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'($urandom_range(255)));
    send_byte(ver);
    send_byte(SYNC_C);
    send_byte(SYNC_D);
    send_byte(8'($urandom_range(255)));
    send_byte(code);
    send_byte(speed);
    send_byte(ofs[15:8]);
    send_byte(ofs[7:0]);
    send_byte(start[15:8]);
    send_byte(start[7:0]);
  endtask

  // Near distances and the extreme signal bytes are placed on purpose when asked.
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] code,
                            input logic [7:0] speed, input logic [15:0] ofs,
                            input logic [15:0] start, input bit pick_extremes);
    logic [7:0]  sig;
    logic [15:0] range_word;
    send_header(ver, code, speed, ofs, start);
    for (int g = 0; g < POINTS_PER_SECTOR; g++) begin
      sig        = 8'($urandom_range(255));
      range_word = 16'($urandom_range(65535));
      if ($urandom_range(9) == 0) range_word = 16'($urandom_range(3));
      if (pick_extremes) begin
        case (g % 6)
          0: range_word = 16'd0;
          1: range_word = 16'd1;
          2: range_word = 16'd2;
          3: range_word = 16'd3;
          4: range_word = 16'hFFFF;
          default: range_word = 16'h0100;
        endcase
        if (g == 0) sig = 8'h00;
        if (g == 1) sig = 8'hFF;
      end
      send_byte(sig);
      send_byte(range_word[15:8]);
      send_byte(range_word[7:0]);
      repeat (3) send_byte(8'($urandom_range(255)));
    end
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
  endtask

  // A header cut short by one wrong byte at a checked position.
  task automatic send_broken_header();
    logic [7:0] hdr [6];
    int         cut;
    hdr = '{SYNC_A, SYNC_B, 8'($urandom_range(255)), 8'($urandom_range(255)), SYNC_C, SYNC_D};
    case ($urandom_range(2))
      0: cut = 1;
      1: cut = 4;
      default: cut = 5;
    endcase
    hdr[cut] = hdr[cut] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i <= cut; i++) send_byte(hdr[i]);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 20);
    repeat (n) begin
      if ($urandom_range(3) == 0) send_byte(SYNC_A);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int budget);
    int          goal;
    int          pick;
    logic [15:0] start;
    goal = bytes_sent + budget;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(3) != 0) start = 16'($urandom_range(15 * 2250 - 1));
        else start = 16'($urandom_range(65535));
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 16'($urandom_range(65535)), start, 1'b0);
      end else if (pick < 85) begin
        send_noise();
      end else begin
        send_broken_header();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A second sync byte in place of the zero is not taken as a new start.
    send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'h12);
    // Mismatches at the third and fourth sync bytes.
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h60);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(SYNC_C);
    send_byte(8'hAC);

    send_frame(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1);
    send_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'd36000, 1'b1);
    send_frame(8'h5A, 8'h04, 8'h80, 16'h8001, 16'hFFFF, 1'b0);
    send_frame(8'hA5, 8'h05, 8'h01, 16'h00FF, 16'd33749, 1'b0);
    drain();

    random_traffic(RANDOM_BYTES / 4);
    drain();
    send_idle_pct = 64;
    random_traffic(RANDOM_BYTES / 4);
    drain();
    send_idle_pct = 0;
    stall_pct     = 64;
    random_traffic(RANDOM_BYTES / 4);
    drain();
    send_idle_pct = 36;
    stall_pct     = 36;
    random_traffic(RANDOM_BYTES / 4);
    drain();
    repeat (32) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
